[design/hrrn_pkg.sv]
// ----------------------------------------------------------------------------
// hrrn_pkg
// Shared widths, result record and scheduler state codes for the HRRN block.
// ----------------------------------------------------------------------------
package hrrn_pkg;

  localparam int FIELD_W = 16;
  localparam int PNUM_W  = 7;
  localparam int CTIME_W = 23;
  localparam int SUM_W   = 29;

  typedef struct packed {
    logic [PNUM_W-1:0]  process_number;
    logic [FIELD_W-1:0] arrival_out;
    logic [FIELD_W-1:0] burst_out;
    logic [CTIME_W-1:0] completion_time;
    logic [CTIME_W-1:0] turnaround_time;
    logic [CTIME_W-1:0] waiting_time;
    logic [SUM_W-1:0]   total_turnaround;
    logic [SUM_W-1:0]   total_waiting;
    logic               last_result;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MUL_L,
    ST_MUL_R,
    ST_CMP,
    ST_PICK,
    ST_CALC,
    ST_TAT,
    ST_EMIT
  } back_state_e;

endpackage

[design/hrrn_ram.sv]
// ----------------------------------------------------------------------------
// hrrn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hrrn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/hrrn_fifo.sv]
// ----------------------------------------------------------------------------
// hrrn_fifo
// Small synchronous queue used between the loader and the scheduler and
// in front of the result port.
// ----------------------------------------------------------------------------
module hrrn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[design/hrrn_front.sv]
// ----------------------------------------------------------------------------
// hrrn_front
// Loader: writes each process, up to MAX_PROCS per batch, into the current bank of the process store
// and hands a finished batch (bank, count) to the scheduler queue.
// ----------------------------------------------------------------------------
module hrrn_front #(
  parameter int MAX_PROCS = 16,
  parameter int IW        = 4,
  parameter int CW        = 5,
  parameter int SW        = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [hrrn_pkg::FIELD_W-1:0] arrival_i,
  input  logic [hrrn_pkg::FIELD_W-1:0] burst_i,
  input  logic                        final_i,
  output logic                        full_o,
  input  logic                        job_full_i,
  output logic                        job_push_o,
  output logic                        job_bank_o,
  output logic [CW-1:0]               job_count_o,
  output logic                        ram_we_o,
  output logic [IW:0]                 ram_waddr_o,
  output logic [2*SW-1:0]             ram_wdata_o
);

  import hrrn_pkg::*;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          bank_q, bank_d;
  logic          accept;
  logic          room;

  assign full_o      = job_full_i;
  assign accept      = push_i && !job_full_i;
  assign room        = (cnt_q < CW'(MAX_PROCS));
  assign ram_we_o    = accept && room;
  assign ram_waddr_o = {bank_q, cnt_q[IW-1:0]};
  assign ram_wdata_o = {arrival_i[SW-1:0], burst_i[SW-1:0]};
  assign job_push_o  = accept && final_i;
  assign job_bank_o  = bank_q;
  assign job_count_o = room ? cnt_q + CW'(1) : cnt_q;

  always_comb begin
    cnt_d  = cnt_q;
    bank_d = bank_q;
    if (accept) begin
      if (final_i) begin
        cnt_d  = '0;
        bank_d = !bank_q;
      end else if (room) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      bank_q <= bank_d;
    end
  end

endmodule

[design/hrrn_back.sv]
// ----------------------------------------------------------------------------
// hrrn_back
// Scheduler: for each choice scans the batch once, tracking the best
// arrived process by exact ratio compare plus the earliest waiting process,
// then emits one result item per process.
// ----------------------------------------------------------------------------
module hrrn_back #(
  parameter int IW = 4,
  parameter int CW = 5,
  parameter int SW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  logic           job_bank_i,
  input  logic [CW-1:0]  job_count_i,
  output logic           job_pop_o,
  output logic           ram_re_o,
  output logic [IW:0]    ram_raddr_o,
  input  logic [2*SW-1:0] ram_rdata_i,
  input  logic           res_full_i,
  output logic           res_push_o,
  output hrrn_pkg::res_t res_o
);

  import hrrn_pkg::*;

  localparam int NSLOT = 1 << IW;
  localparam int NA_W  = CTIME_W + 1;
  localparam int PR_W  = NA_W + SW;

  back_state_e state_q, state_d;

  logic [CW-1:0]      s_q, k_q;
  logic [CTIME_W-1:0] t_q;
  logic [SUM_W-1:0]   sum_t_q, sum_w_q;
  logic [NSLOT-1:0]   done_q;

  logic               e_v_q, z_v_q, b_v_q;
  logic [SW-1:0]      e_a_q, e_b_q, z_a_q, b_a_q, b_b_q;
  logic [IW-1:0]      e_i_q, z_i_q, b_i_q;

  logic [SW-1:0]      cand_a_q, cand_b_q;
  logic [NA_W-1:0]    na_q, nb_q;
  logic [PR_W-1:0]    lhs_q, rhs_q;

  logic [SW-1:0]      sel_a_q, sel_b_q;
  logic [IW-1:0]      sel_i_q;
  logic [CTIME_W-1:0] comp_q, wt_q, tat_q;

  logic [SW-1:0]      rd_a, rd_b;
  logic               cand_done, cand_arr, take, need_mul, mul_path;
  logic               scan_last, emit_last, advance;
  logic [SUM_W-1:0]   sum_t_nx, sum_w_nx;

  assign rd_a      = ram_rdata_i[2*SW-1:SW];
  assign rd_b      = ram_rdata_i[SW-1:0];
  assign cand_done = done_q[s_q[IW-1:0]];
  assign cand_arr  = (CTIME_W'(rd_a) <= t_q);
  assign scan_last = ((s_q + CW'(1)) == job_count_i);
  assign emit_last = ((k_q + CW'(1)) == job_count_i);
  assign mul_path  = !cand_done && cand_arr && need_mul;
  assign advance   = (state_q == ST_EVAL && !mul_path) || (state_q == ST_CMP);
  assign sum_t_nx  = sum_t_q + SUM_W'(tat_q);
  assign sum_w_nx  = sum_w_q + SUM_W'(wt_q);

  always_comb begin
    take     = 1'b0;
    need_mul = 1'b0;
    priority if (!b_v_q) begin
      take = 1'b1;
    end else if (rd_b == '0 && b_b_q != '0) begin
      take = 1'b1;
    end else if (b_b_q == '0) begin
      take = (rd_b == '0) && (rd_a < b_a_q);
    end else begin
      need_mul = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_EVAL;
      ST_EVAL: begin
        if (mul_path) begin
          state_d = ST_MUL_L;
        end else begin
          state_d = scan_last ? ST_PICK : ST_READ;
        end
      end
      ST_MUL_L: state_d = ST_MUL_R;
      ST_MUL_R: state_d = ST_CMP;
      ST_CMP:   state_d = scan_last ? ST_PICK : ST_READ;
      ST_PICK:  state_d = ST_CALC;
      ST_CALC:  state_d = ST_TAT;
      ST_TAT:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (!res_full_i) begin
          state_d = emit_last ? ST_IDLE : ST_READ;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re_o    = (state_q == ST_READ);
    ram_raddr_o = {job_bank_i, s_q[IW-1:0]};
    res_push_o  = (state_q == ST_EMIT) && !res_full_i;
    job_pop_o   = res_push_o && emit_last;

    res_o.process_number   = PNUM_W'(sel_i_q) + PNUM_W'(1);
    res_o.arrival_out      = FIELD_W'(sel_a_q);
    res_o.burst_out        = FIELD_W'(sel_b_q);
    res_o.completion_time  = comp_q;
    res_o.turnaround_time  = tat_q;
    res_o.waiting_time     = wt_q;
    res_o.total_turnaround = sum_t_nx;
    res_o.total_waiting    = sum_w_nx;
    res_o.last_result      = emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and batch state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q     <= '0;
      k_q     <= '0;
      t_q     <= '0;
      sum_t_q <= '0;
      sum_w_q <= '0;
      done_q  <= '0;
      e_v_q   <= 1'b0;
      z_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
    end else begin
      if (advance && !scan_last) begin
        s_q <= s_q + CW'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          s_q     <= '0;
          k_q     <= '0;
          t_q     <= '0;
          sum_t_q <= '0;
          sum_w_q <= '0;
          done_q  <= '0;
          e_v_q   <= 1'b0;
          z_v_q   <= 1'b0;
          b_v_q   <= 1'b0;
        end
        ST_EVAL: begin
          if (!cand_done) begin
            if (!e_v_q || rd_a < e_a_q) e_v_q <= 1'b1;
            if (rd_b == '0 && (!z_v_q || rd_a < z_a_q)) z_v_q <= 1'b1;
            if (cand_arr && take) b_v_q <= 1'b1;
          end
        end
        ST_PICK: begin
          if (!b_v_q) t_q <= CTIME_W'(e_a_q);
        end
        ST_EMIT: begin
          if (!res_full_i) begin
            sum_t_q                <= sum_t_nx;
            sum_w_q                <= sum_w_nx;
            t_q                    <= comp_q;
            done_q[sel_i_q]        <= 1'b1;
            k_q                    <= k_q + CW'(1);
            s_q                    <= '0;
            e_v_q                  <= 1'b0;
            z_v_q                  <= 1'b0;
            b_v_q                  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // candidate, tracker and result datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_EVAL: begin
        cand_a_q <= rd_a;
        cand_b_q <= rd_b;
        na_q     <= NA_W'(t_q) - NA_W'(rd_a) + NA_W'(rd_b);
        nb_q     <= NA_W'(t_q) - NA_W'(b_a_q) + NA_W'(b_b_q);
        if (!cand_done) begin
          if (!e_v_q || rd_a < e_a_q) begin
            e_a_q <= rd_a;
            e_b_q <= rd_b;
            e_i_q <= s_q[IW-1:0];
          end
          if (rd_b == '0 && (!z_v_q || rd_a < z_a_q)) begin
            z_a_q <= rd_a;
            z_i_q <= s_q[IW-1:0];
          end
          if (cand_arr && take) begin
            b_a_q <= rd_a;
            b_b_q <= rd_b;
            b_i_q <= s_q[IW-1:0];
          end
        end
      end
      ST_MUL_L: lhs_q <= PR_W'(na_q) * PR_W'(b_b_q);
      ST_MUL_R: rhs_q <= PR_W'(nb_q) * PR_W'(cand_b_q);
      ST_CMP: begin
        if ((lhs_q != rhs_q) ? (lhs_q > rhs_q) : (cand_a_q < b_a_q)) begin
          b_a_q <= cand_a_q;
          b_b_q <= cand_b_q;
          b_i_q <= s_q[IW-1:0];
        end
      end
      ST_PICK: begin
        priority if (b_v_q) begin
          sel_a_q <= b_a_q;
          sel_b_q <= b_b_q;
          sel_i_q <= b_i_q;
        end else if (z_v_q && z_a_q == e_a_q) begin
          sel_a_q <= z_a_q;
          sel_b_q <= '0;
          sel_i_q <= z_i_q;
        end else begin
          sel_a_q <= e_a_q;
          sel_b_q <= e_b_q;
          sel_i_q <= e_i_q;
        end
      end
      ST_CALC: begin
        comp_q <= t_q + CTIME_W'(sel_b_q);
        wt_q   <= t_q - CTIME_W'(sel_a_q);
      end
      ST_TAT:  tat_q <= wt_q + CTIME_W'(sel_b_q);
      default: ;
    endcase
  end

endmodule

[design/hrrn_process_scheduler.sv]
// ----------------------------------------------------------------------------
// hrrn_process_scheduler
// Non-preemptive highest-response-ratio-next scheduler over a loaded batch.
//
//   channel  handshake          moves            per item
//   load     push / full        process item     arrival, burst, final flag
//   result   pop / empty        result item      number, times, running sums
//
// Loading accepts one item per cycle while full is low; full is high while two
// closed batches are queued, the one in progress included. Each of the N
// choices of a batch scans the store entry by entry (read, then evaluate),
// adding a left and a right multiply and a compare where two finite ratios
// are cross-multiplied (at most N-1 per scan), then picks, computes the times
// and emits. Two store banks and a two-deep batch queue let the next batch
// load while one is scheduled; a two-deep result queue absorbs stalls on pop.
// Reset clears control state only; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module hrrn_process_scheduler #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [hrrn_pkg::FIELD_W-1:0] arrival_time_i,
  input  logic [hrrn_pkg::FIELD_W-1:0] burst_time_i,
  input  logic                         final_entry_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [hrrn_pkg::PNUM_W-1:0]  process_number_o,
  output logic [hrrn_pkg::FIELD_W-1:0] arrival_out_o,
  output logic [hrrn_pkg::FIELD_W-1:0] burst_out_o,
  output logic [hrrn_pkg::CTIME_W-1:0] completion_time_o,
  output logic [hrrn_pkg::CTIME_W-1:0] turnaround_time_o,
  output logic [hrrn_pkg::CTIME_W-1:0] waiting_time_o,
  output logic [hrrn_pkg::SUM_W-1:0]   total_turnaround_o,
  output logic [hrrn_pkg::SUM_W-1:0]   total_waiting_o,
  output logic                         last_result_o
);

  import hrrn_pkg::*;

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int SW = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;

  logic          job_full, job_empty, job_push, job_pop;
  logic          job_bank_in, job_bank_out;
  logic [CW-1:0] job_count_in, job_count_out;

  logic           ram_we, ram_re;
  logic [IW:0]    ram_waddr, ram_raddr;
  logic [2*SW-1:0] ram_wdata, ram_rdata;

  logic res_full, res_push;
  res_t res_in, res_head;

  hrrn_front #(
    .MAX_PROCS(MAX_PROCS),
    .IW       (IW),
    .CW       (CW),
    .SW       (SW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .arrival_i  (arrival_time_i),
    .burst_i    (burst_time_i),
    .final_i    (final_entry_i),
    .full_o     (full),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_bank_o (job_bank_in),
    .job_count_o(job_count_in),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  hrrn_ram #(
    .WIDTH(2 * SW),
    .DEPTH(1 << (IW + 1))
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  hrrn_fifo #(
    .WIDTH(CW + 1),
    .DEPTH(2)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i ({job_bank_in, job_count_in}),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o ({job_bank_out, job_count_out}),
    .empty_o(job_empty)
  );

  hrrn_back #(
    .IW(IW),
    .CW(CW),
    .SW(SW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_bank_i (job_bank_out),
    .job_count_i(job_count_out),
    .job_pop_o  (job_pop),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  hrrn_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head),
    .empty_o(empty)
  );

  assign process_number_o   = res_head.process_number;
  assign arrival_out_o      = res_head.arrival_out;
  assign burst_out_o        = res_head.burst_out;
  assign completion_time_o  = res_head.completion_time;
  assign turnaround_time_o  = res_head.turnaround_time;
  assign waiting_time_o     = res_head.waiting_time;
  assign total_turnaround_o = res_head.total_turnaround;
  assign total_waiting_o    = res_head.total_waiting;
  assign last_result_o      = res_head.last_result;

endmodule
